FILE: rtl/dsdf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dsdf_pkg
// shared types, constants and the segment table for the display feeder
// ---------------------------------------------------------------------------
package dsdf_pkg;

    localparam int VALUE_W        = 27;
    localparam int ADDR_W         = 4;
    localparam int SEG_W          = 8;
    localparam int PANEL_DIGITS   = 8;
    localparam int BCD_W          = 4 * PANEL_DIGITS;
    localparam int DIGITS_DEFAULT = 8;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 16;
    localparam int DP_BIT         = 7;
    localparam int MIN_SHOWN      = 3;   // minimum digits written for a nonzero value, zero padded
    localparam int BIT_CNT_W      = $clog2(VALUE_W);

    localparam logic [ADDR_W-1:0] ADDR_FIRST = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(PANEL_DIGITS);
    localparam logic [ADDR_W-1:0] ADDR_DP    = ADDR_W'(3);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_BLANK,
        B_DIGIT
    } back_state_t;

    // one display update, handed from the front end to the write sequencer
    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [ADDR_W-1:0] top;     // highest digit address to write
        logic              blank;   // clear all digits first
        logic              zero;    // value zero: blank digit 1 only
    } cmd_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'b0111_1110;
            4'd1:    seg = 8'b0011_0000;
            4'd2:    seg = 8'b0110_1101;
            4'd3:    seg = 8'b0111_1001;
            4'd4:    seg = 8'b0011_0011;
            4'd5:    seg = 8'b0101_1011;
            4'd6:    seg = 8'b0101_1111;
            4'd7:    seg = 8'b0111_0000;
            4'd8:    seg = 8'b0111_1111;
            4'd9:    seg = 8'b0111_1011;
            default: seg = 8'b0000_0000;
        endcase
        return seg;
    endfunction

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/decimal_seven_segment_display_feeder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// decimal_seven_segment_display_feeder
// turns an unsigned value into digit register writes for an 8-digit display
// ---------------------------------------------------------------------------
// usage
//   s_ channel: one transaction per value to show (27-bit unsigned in tdata)
//   m_ channel: one transaction per display register write; tlast marks the
//   final write caused by a value
//   values above 10^DIGITS - 1 saturate; for a nonzero value at least three
//   digits are written with digit 3 carrying the decimal point, for zero just
//   digit 1, left blank; a shorter number than the one shown before first
//   blanks all eight digits (addresses 1 up to 8)
// sequencing
//   the front end accepts a value, runs the 27 shift-and-add steps of the bcd
//   conversion and then queues the command; it takes no new value before that
//   the write sequencer fetches a command and then emits its writes, up to 16,
//   one write per cycle while the receiver keeps up, the blanking writes first;
//   the front end can convert the next value while these writes go out
// reset and stalls
//   reset clears the shown digit count, the queue and the output valid flag
//   a stalled receiver holds the output register; the two-entry command
//   queue lets the front end keep accepting until it fills
// ---------------------------------------------------------------------------
module decimal_seven_segment_display_feeder #(
    parameter int DIGITS = dsdf_pkg::DIGITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dsdf_pkg::S_TDATA_W-1:0]    s_tdata,   // [26:0] value
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [3:0] digit_address, [11:4] segment_data
    output logic [dsdf_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast
);

    // command handoff between front end and sequencer
    dsdf_pkg::cmd_t                 push_cmd;
    dsdf_pkg::cmd_t                 pop_cmd;
    logic                           push, full, pop, empty;
    logic [dsdf_pkg::ADDR_W-1:0]    out_addr;
    logic [dsdf_pkg::SEG_W-1:0]     out_seg;

    // front end: saturate, convert to bcd, compare with digit count shown
    dsdf_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_value (s_tdata[dsdf_pkg::VALUE_W-1:0]),
        .push     (push),
        .full     (full),
        .cmd      (push_cmd)
    );

    // decouples conversion from the write bursts
    dsdf_cmd_fifo #(
        .DEPTH (dsdf_pkg::CMD_FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    // back end: emits the register writes through an output register
    dsdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_addr  (out_addr),
        .out_seg   (out_seg),
        .out_last  (m_tlast)
    );

    // tdata packing, upper bits zero
    assign m_tdata = {{(dsdf_pkg::M_TDATA_W - dsdf_pkg::ADDR_W - dsdf_pkg::SEG_W){1'b0}},
                      out_seg, out_addr};

    // every write targets a real digit register
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_addr >= dsdf_pkg::ADDR_FIRST) && (out_addr <= dsdf_pkg::ADDR_LAST))
        else $error("digit address out of range");

    // decimal point only on digit 3
    a_dp_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_seg[dsdf_pkg::DP_BIT] |-> out_addr == dsdf_pkg::ADDR_DP)
        else $error("decimal point on wrong digit");

    // a burst always ends on digit 1
    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_addr == dsdf_pkg::ADDR_FIRST)
        else $error("last write not on digit 1");

    // the front end never offers a command the queue cannot take
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue overflow");

endmodule
`default_nettype wire

FILE: rtl/dsdf_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dsdf_front
// accepts a value, saturates it, converts to bcd and classifies the update
// ---------------------------------------------------------------------------
module dsdf_front #(
    parameter int DIGITS = dsdf_pkg::DIGITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dsdf_pkg::VALUE_W-1:0]  in_value,
    output logic                               push,
    input  wire logic                          full,
    output dsdf_pkg::cmd_t                     cmd
);

    localparam logic [dsdf_pkg::VALUE_W-1:0] LIMIT =
        dsdf_pkg::VALUE_W'(dsdf_pkg::pow10(DIGITS) - 1);
    localparam logic [dsdf_pkg::BIT_CNT_W-1:0] LAST_BIT =
        dsdf_pkg::BIT_CNT_W'(dsdf_pkg::VALUE_W - 1);

    dsdf_pkg::front_state_t state_reg, state_next;

    logic [dsdf_pkg::VALUE_W-1:0]   bin_reg, bin_next;
    logic [dsdf_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic [dsdf_pkg::BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [dsdf_pkg::ADDR_W-1:0]    shown_reg, shown_next;

    logic [dsdf_pkg::BCD_W-1:0]     bcd_adj;
    logic [dsdf_pkg::ADDR_W-1:0]    sig_cnt;
    logic                           is_zero;

    // add-3 correction per nibble
    always_comb begin
        for (int i = 0; i < dsdf_pkg::PANEL_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // significant digit count of the converted value
    always_comb begin
        sig_cnt = '0;
        for (int i = 0; i < dsdf_pkg::PANEL_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                sig_cnt = dsdf_pkg::ADDR_W'(i + 1);
            end
        end
    end

    assign is_zero = (sig_cnt == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsdf_pkg::F_IDLE: begin
                if (in_valid) begin
                    state_next = dsdf_pkg::F_CONV;
                end
            end
            dsdf_pkg::F_CONV: begin
                if (bit_reg == LAST_BIT) begin
                    state_next = dsdf_pkg::F_PUSH;
                end
            end
            dsdf_pkg::F_PUSH: begin
                if (!full) begin
                    state_next = dsdf_pkg::F_IDLE;
                end
            end
            default: state_next = dsdf_pkg::F_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        in_ready   = 1'b0;
        push       = 1'b0;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        bit_next   = bit_reg;
        shown_next = shown_reg;
        cmd.bcd    = bcd_reg;
        cmd.zero   = is_zero;
        cmd.top    = (sig_cnt < dsdf_pkg::ADDR_DP) ? dsdf_pkg::ADDR_DP : sig_cnt;
        cmd.blank  = is_zero ? (shown_reg > dsdf_pkg::ADDR_FIRST) : (sig_cnt < shown_reg);
        unique case (state_reg)
            dsdf_pkg::F_IDLE: begin
                in_ready = 1'b1;
                bin_next = (in_value > LIMIT) ? LIMIT : in_value;
                bcd_next = '0;
                bit_next = '0;
            end
            dsdf_pkg::F_CONV: begin
                bcd_next = {bcd_adj[dsdf_pkg::BCD_W-2:0], bin_reg[dsdf_pkg::VALUE_W-1]};
                bin_next = {bin_reg[dsdf_pkg::VALUE_W-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
            end
            dsdf_pkg::F_PUSH: begin
                push = !full;
                if (!full) begin
                    shown_next = is_zero ? dsdf_pkg::ADDR_FIRST : sig_cnt;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsdf_pkg::F_IDLE;
            shown_reg <= '0;
        end else begin
            state_reg <= state_next;
            shown_reg <= shown_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        bit_reg <= bit_next;
    end

endmodule
`default_nettype wire

FILE: rtl/dsdf_cmd_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dsdf_cmd_fifo
// short command queue between the front end and the write sequencer
// ---------------------------------------------------------------------------
module dsdf_cmd_fifo #(
    parameter int DEPTH = dsdf_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire dsdf_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output dsdf_pkg::cmd_t      pop_cmd,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dsdf_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_MAX) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_MAX) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dsdf_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dsdf_back
// write sequencer: blanking pass when requested, then digits from the top down to digit 1
// ---------------------------------------------------------------------------
module dsdf_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         empty,
    input  wire dsdf_pkg::cmd_t               pop_cmd,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [dsdf_pkg::ADDR_W-1:0]       out_addr,
    output logic [dsdf_pkg::SEG_W-1:0]        out_seg,
    output logic                              out_last
);

    dsdf_pkg::back_state_t state_reg, state_next;

    dsdf_pkg::cmd_t                cmd_reg, cmd_next;
    logic [dsdf_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic                          valid_reg, valid_next;
    logic [dsdf_pkg::ADDR_W-1:0]   oaddr_reg, oaddr_next;
    logic [dsdf_pkg::SEG_W-1:0]    oseg_reg, oseg_next;
    logic                          olast_reg, olast_next;

    logic                          advance;
    logic [dsdf_pkg::ADDR_W-1:0]   addr_m1;
    logic [2:0]                    dig_idx;
    logic [3:0]                    digit;
    logic [dsdf_pkg::SEG_W-1:0]    seg_val;
    logic [dsdf_pkg::ADDR_W-1:0]   first_digit;

    // output register free or being drained
    assign advance     = !valid_reg || out_ready;
    assign addr_m1     = addr_reg - 1'b1;
    assign dig_idx     = addr_m1[2:0];
    assign digit       = cmd_reg.bcd[4*dig_idx +: 4];
    assign first_digit = cmd_reg.zero ? dsdf_pkg::ADDR_FIRST : cmd_reg.top;

    always_comb begin
        seg_val = dsdf_pkg::seg_pattern(digit);
        if (addr_reg == dsdf_pkg::ADDR_DP) begin
            seg_val[dsdf_pkg::DP_BIT] = 1'b1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsdf_pkg::B_IDLE: begin
                if (!empty) begin
                    state_next = pop_cmd.blank ? dsdf_pkg::B_BLANK : dsdf_pkg::B_DIGIT;
                end
            end
            dsdf_pkg::B_BLANK: begin
                if (advance && addr_reg == dsdf_pkg::ADDR_LAST) begin
                    state_next = dsdf_pkg::B_DIGIT;
                end
            end
            dsdf_pkg::B_DIGIT: begin
                if (advance && addr_reg == dsdf_pkg::ADDR_FIRST) begin
                    state_next = dsdf_pkg::B_IDLE;
                end
            end
            default: state_next = dsdf_pkg::B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        pop        = 1'b0;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        valid_next = valid_reg && !out_ready;
        oaddr_next = oaddr_reg;
        oseg_next  = oseg_reg;
        olast_next = olast_reg;
        unique case (state_reg)
            dsdf_pkg::B_IDLE: begin
                if (!empty) begin
                    pop      = 1'b1;
                    cmd_next = pop_cmd;
                    if (pop_cmd.blank) begin
                        addr_next = dsdf_pkg::ADDR_FIRST;
                    end else begin
                        addr_next = pop_cmd.zero ? dsdf_pkg::ADDR_FIRST : pop_cmd.top;
                    end
                end
            end
            dsdf_pkg::B_BLANK: begin
                if (advance) begin
                    valid_next = 1'b1;
                    oaddr_next = addr_reg;
                    oseg_next  = '0;
                    olast_next = 1'b0;
                    addr_next  = (addr_reg == dsdf_pkg::ADDR_LAST) ? first_digit
                                                                   : addr_reg + 1'b1;
                end
            end
            dsdf_pkg::B_DIGIT: begin
                if (advance) begin
                    valid_next = 1'b1;
                    oaddr_next = addr_reg;
                    oseg_next  = cmd_reg.zero ? '0 : seg_val;
                    olast_next = (addr_reg == dsdf_pkg::ADDR_FIRST);
                    addr_next  = addr_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsdf_pkg::B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        cmd_reg   <= cmd_next;
        addr_reg  <= addr_next;
        oaddr_reg <= oaddr_next;
        oseg_reg  <= oseg_next;
        olast_reg <= olast_next;
    end

    assign out_valid = valid_reg;
    assign out_addr  = oaddr_reg;
    assign out_seg   = oseg_reg;
    assign out_last  = olast_reg;

endmodule
`default_nettype wire
